>>> rtl/skf_pkg.sv
`default_nettype none
package skf_pkg;

	localparam int CHANNELS_DEF = 8;
	localparam int CH_W         = 3;
	localparam int SAMPLE_W     = 16;
	localparam int DATA_W       = 32;
	localparam int GAIN_W       = 16;
	localparam int DIV_STEPS    = GAIN_W;
	localparam int DIV_CNT_W    = $clog2(DIV_STEPS);
	localparam int CFG_IDX_W    = 1;
	localparam int S_TDATA_W    = 24;
	localparam int M_TDATA_W    = 40;

	localparam logic [DATA_W-1:0] PROCESS_NOISE_RST = 32'd1311;
	localparam logic [DATA_W-1:0] MEASURE_NOISE_RST = 32'd3493068;

	localparam logic [CFG_IDX_W-1:0] REG_PROCESS_NOISE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_MEASURE_NOISE = 1'b1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SUM,
		S_DEN,
		S_DIV,
		S_MUL1,
		S_MUL2,
		S_WB
	} state_t;

	typedef struct packed {
		logic load;
		logic sum;
		logic den;
		logic div;
		logic mul1;
		logic mul2;
		logic wb;
	} cmd_t;

	typedef struct packed {
		logic oor_in;
		logic out_free;
	} stat_t;

endpackage
`default_nettype wire

>>> rtl/skf_ctrl.sv
`default_nettype none
module skf_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           s_tvalid,
	output logic                s_tready,
	input  wire skf_pkg::stat_t stat,
	output skf_pkg::cmd_t       cmd
);

	skf_pkg::state_t state_q, state_d;
	logic [skf_pkg::DIV_CNT_W-1:0] cnt_q;
	logic accept;
	logic div_last;

	assign accept   = s_tvalid && s_tready;
	assign div_last = (cnt_q == skf_pkg::DIV_CNT_W'(skf_pkg::DIV_STEPS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= skf_pkg::S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == skf_pkg::S_DIV) begin
				cnt_q <= cnt_q + 1'b1;
			end else begin
				cnt_q <= '0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			skf_pkg::S_IDLE: begin
				if (accept) begin
					// out-of-range channel skips the arithmetic
					state_d = stat.oor_in ? skf_pkg::S_WB : skf_pkg::S_SUM;
				end
			end
			skf_pkg::S_SUM:  state_d = skf_pkg::S_DEN;
			skf_pkg::S_DEN:  state_d = skf_pkg::S_DIV;
			skf_pkg::S_DIV: begin
				if (div_last) begin
					state_d = skf_pkg::S_MUL1;
				end
			end
			skf_pkg::S_MUL1: state_d = skf_pkg::S_MUL2;
			skf_pkg::S_MUL2: state_d = skf_pkg::S_WB;
			skf_pkg::S_WB: begin
				if (stat.out_free) begin
					state_d = skf_pkg::S_IDLE;
				end
			end
			default:         state_d = skf_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		s_tready = 1'b0;
		cmd      = '0;
		case (state_q)
			skf_pkg::S_IDLE: begin
				s_tready = 1'b1;
				cmd.load = s_tvalid;
			end
			skf_pkg::S_SUM:  cmd.sum  = 1'b1;
			skf_pkg::S_DEN:  cmd.den  = 1'b1;
			skf_pkg::S_DIV:  cmd.div  = 1'b1;
			skf_pkg::S_MUL1: cmd.mul1 = 1'b1;
			skf_pkg::S_MUL2: cmd.mul2 = 1'b1;
			skf_pkg::S_WB:   cmd.wb   = stat.out_free;
			default: begin
				s_tready = 1'b0;
				cmd      = '0;
			end
		endcase
	end

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q != skf_pkg::S_IDLE))
		else $error("accepted word did not start work");

	a_div_runs_full: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == skf_pkg::S_DIV && div_last) |=> (state_q == skf_pkg::S_MUL1))
		else $error("divider did not finish after its last step");

	a_wb_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == skf_pkg::S_WB && stat.out_free) |=> (state_q == skf_pkg::S_IDLE))
		else $error("write-back did not return to idle");

	a_wb_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == skf_pkg::S_WB && !stat.out_free) |=> (state_q == skf_pkg::S_WB))
		else $error("write-back left while output was full");

endmodule
`default_nettype wire

>>> rtl/skf_dp.sv
`default_nettype none
module skf_dp #(
	parameter int CHANNELS = skf_pkg::CHANNELS_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire skf_pkg::cmd_t                       cmd,
	output skf_pkg::stat_t                           stat,
	input  wire logic [skf_pkg::S_TDATA_W-1:0]       s_tdata,
	output logic                                     m_tvalid,
	input  wire logic                                m_tready,
	output logic [skf_pkg::M_TDATA_W-1:0]            m_tdata,
	input  wire logic                                cfg_we,
	input  wire logic [skf_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [skf_pkg::DATA_W-1:0]          cfg_data
);

	localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int DW = skf_pkg::DATA_W;
	localparam int GW = skf_pkg::GAIN_W;

	logic [DW-1:0] q_q, r_q;
	logic [DW-1:0] est_q [CHANNELS];
	logic [DW-1:0] var_q [CHANNELS];

	logic [skf_pkg::CH_W-1:0]     in_ch;
	logic [skf_pkg::SAMPLE_W-1:0] in_sample;
	logic [CH_IDX_W-1:0]          rd_idx, wr_idx;

	logic [skf_pkg::CH_W-1:0]     ch_q;
	logic [skf_pkg::SAMPLE_W-1:0] sample_q;
	logic                         oor_q;
	logic [DW-1:0]                x_q, p_q, pm_q, diff_q;
	logic                         ge_q, rz_q;
	logic [DW:0]                  den_q, rem_q;
	logic [GW-1:0]                quo_q, gain_q;
	logic [DW-1:0]                step_q, pn_q;

	logic [DW:0]   pm_sum;
	logic [DW-1:0] s_full;
	logic [DW+1:0] rem_sh;
	logic          q_bit;
	logic [GW-1:0] gain_eff;
	logic [GW:0]   mul_a;
	logic [DW-1:0] mul_b;
	logic [GW+DW:0] prod;
	logic [DW-1:0] xn;

	logic                         out_valid_q;
	logic [skf_pkg::CH_W-1:0]     out_ch_q;
	logic [DW-1:0]                out_est_q;

	assign in_ch     = s_tdata[skf_pkg::CH_W-1:0];
	assign in_sample = s_tdata[skf_pkg::CH_W +: skf_pkg::SAMPLE_W];
	assign rd_idx    = CH_IDX_W'(in_ch);
	assign wr_idx    = CH_IDX_W'(ch_q);

	assign stat.oor_in   = ({1'b0, in_ch} >= 4'(CHANNELS)) && (CHANNELS < 16);
	assign stat.out_free = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_q <= skf_pkg::PROCESS_NOISE_RST;
			r_q <= skf_pkg::MEASURE_NOISE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				skf_pkg::REG_PROCESS_NOISE: q_q <= cfg_data;
				skf_pkg::REG_MEASURE_NOISE: r_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				est_q[i] <= '0;
				var_q[i] <= '0;
			end
		end else if (cmd.wb && !oor_q) begin
			est_q[wr_idx] <= xn;
			var_q[wr_idx] <= pn_q;
		end
	end

	assign pm_sum = {1'b0, p_q} + {1'b0, q_q};
	assign s_full = {sample_q, 16'd0};

	// restoring divide, remainder stays below the denominator while r is nonzero
	assign rem_sh = {rem_q, 1'b0};
	assign q_bit  = (rem_sh >= {1'b0, den_q});

	// r of zero: exact gain of one saturates, zero variance gives zero gain
	assign gain_eff = rz_q ? {GW{pm_q != '0}} : quo_q;

	assign mul_a = cmd.mul1 ? {1'b0, gain_eff} : ((GW+1)'(1 << GW) - {1'b0, gain_q});
	assign mul_b = cmd.mul1 ? diff_q : pm_q;
	assign prod  = mul_a * mul_b;

	assign xn = ge_q ? (x_q + step_q) : (x_q - step_q);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ch_q     <= in_ch;
			sample_q <= in_sample;
			oor_q    <= stat.oor_in;
			x_q      <= est_q[rd_idx];
			p_q      <= var_q[rd_idx];
		end
		if (cmd.sum) begin
			pm_q <= pm_sum[DW] ? {DW{1'b1}} : pm_sum[DW-1:0];
		end
		if (cmd.den) begin
			den_q  <= {1'b0, pm_q} + {1'b0, r_q};
			rem_q  <= {1'b0, pm_q};
			rz_q   <= (r_q == '0);
			ge_q   <= (s_full >= x_q);
			diff_q <= (s_full >= x_q) ? (s_full - x_q) : (x_q - s_full);
		end
		if (cmd.div) begin
			rem_q <= q_bit ? (DW+1)'(rem_sh - {1'b0, den_q}) : rem_sh[DW:0];
			quo_q <= {quo_q[GW-2:0], q_bit};
		end
		if (cmd.mul1) begin
			gain_q <= gain_eff;
			step_q <= prod[GW +: DW];
		end
		if (cmd.mul2) begin
			pn_q <= prod[GW +: DW];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.wb) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wb) begin
			out_ch_q  <= ch_q;
			out_est_q <= oor_q ? '0 : xn;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'd0, out_est_q, out_ch_q};

endmodule
`default_nettype wire

>>> rtl/scalar_kalman_filter_multichannel_unit.sv
// an out-of-range channel skips the arithmetic; a new word is taken only in idle,
// once the previous one has been through sum, denominator, the 16-step bit-serial
// gain divider, two passes of the shared 17x32 multiplier and write-back
// the result register lets the next word start while a result waits
// reset (arst_n low, asynchronous): all channel estimates and variances zero,
// q and r back to their defaults, no result pending
`default_nettype none
module scalar_kalman_filter_multichannel_unit #(
	parameter int CHANNELS = skf_pkg::CHANNELS_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               s_tvalid,
	output logic                                    s_tready,
	// channel[2:0], sample[18:3], zero pad
	input  wire logic [skf_pkg::S_TDATA_W-1:0]      s_tdata,
	output logic                                    m_tvalid,
	input  wire logic                               m_tready,
	// channel_out[2:0], estimate[34:3], zero pad
	output logic [skf_pkg::M_TDATA_W-1:0]           m_tdata,
	input  wire logic                               cfg_we,
	input  wire logic [skf_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [skf_pkg::DATA_W-1:0]         cfg_data
);

	skf_pkg::cmd_t  cmd;
	skf_pkg::stat_t stat;

	skf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	skf_dp #(
		.CHANNELS (CHANNELS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

endmodule
`default_nettype wire

>>> bench/tb_scalar_kalman_filter_multichannel_unit.sv
module tb_scalar_kalman_filter_multichannel_unit;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NUM_CH = skf_pkg::CHANNELS_DEF;
	localparam int STALL_LIMIT = 3000;
	localparam int SEGMENT_WORDS = 140;

	typedef struct packed {
		logic [skf_pkg::CH_W-1:0]   ch;
		logic [skf_pkg::DATA_W-1:0] est;
	} estimate_t;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            s_tvalid = 1'b0;
	logic                            s_tready;
	logic [skf_pkg::S_TDATA_W-1:0]   s_tdata = '0;
	logic                            m_tvalid;
	logic                            m_tready = 1'b0;
	logic [skf_pkg::M_TDATA_W-1:0]   m_tdata;
	logic                            cfg_we = 1'b0;
	logic [skf_pkg::CFG_IDX_W-1:0]   cfg_index = skf_pkg::REG_PROCESS_NOISE;
	logic [skf_pkg::DATA_W-1:0]      cfg_data = '0;

	// filter state mirrored from the words sent so far
	logic [skf_pkg::DATA_W-1:0] est_mem [NUM_CH];
	logic [skf_pkg::DATA_W-1:0] var_mem [NUM_CH];
	logic [skf_pkg::DATA_W-1:0] q_reg = skf_pkg::PROCESS_NOISE_RST;
	logic [skf_pkg::DATA_W-1:0] r_reg = skf_pkg::MEASURE_NOISE_RST;

	estimate_t estimates_due [$];

	int send_idle_pct = 29;
	int recv_idle_pct = 76;
	int errors = 0;
	int checked = 0;
	int words_sent = 0;
	int noise_settings = 0;
	int stall_cycles = 0;

	scalar_kalman_filter_multichannel_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// one filter step: predict, gain, correct, shrink variance
	function automatic logic [skf_pkg::DATA_W-1:0] kalman_update(
			input logic [skf_pkg::CH_W-1:0] ch,
			input logic [skf_pkg::SAMPLE_W-1:0] smp);
		logic [63:0] s, x, pm, den, g, diff, move, xn, pn;
		if (ch >= NUM_CH)
			return '0;
		s = {32'd0, smp, 16'd0};
		x = {32'd0, est_mem[ch]};
		pm = {32'd0, var_mem[ch]} + {32'd0, q_reg};
		if (pm > 64'hFFFF_FFFF)
			pm = 64'hFFFF_FFFF;
		den = pm + {32'd0, r_reg};
		if (den == 0)
			g = 0;
		else
			g = (pm << 16) / den;
		// exact unity gain does not fit q0.16
		if (g > 64'hFFFF)
			g = 64'hFFFF;
		diff = (s >= x) ? s - x : x - s;
		move = (g * diff) >> 16;
		xn = (s >= x) ? x + move : x - move;
		pn = ((64'd65536 - g) * pm) >> 16;
		est_mem[ch] = xn[31:0];
		var_mem[ch] = pn[31:0];
		return xn[31:0];
	endfunction

	task automatic send_word(input logic [skf_pkg::CH_W-1:0] ch,
			input logic [skf_pkg::SAMPLE_W-1:0] smp);
		estimate_t want;
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {{(skf_pkg::S_TDATA_W - skf_pkg::CH_W - skf_pkg::SAMPLE_W){1'b0}}, smp, ch};
		do
			@(posedge clk);
		while (!s_tready);
		want.ch = ch;
		want.est = kalman_update(ch, smp);
		estimates_due.push_back(want);
		words_sent++;
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (estimates_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// block must be idle when this is called
	task automatic set_noise(input logic [skf_pkg::DATA_W-1:0] q,
			input logic [skf_pkg::DATA_W-1:0] r);
		cfg_we <= 1'b1;
		cfg_index <= skf_pkg::REG_PROCESS_NOISE;
		cfg_data <= q;
		@(posedge clk);
		q_reg = q;
		cfg_index <= skf_pkg::REG_MEASURE_NOISE;
		cfg_data <= r;
		@(posedge clk);
		r_reg = r;
		cfg_we <= 1'b0;
		@(posedge clk);
		noise_settings++;
	endtask

	function automatic logic [skf_pkg::SAMPLE_W-1:0] pick_sample(
			input logic [skf_pkg::CH_W-1:0] ch);
		logic [skf_pkg::SAMPLE_W-1:0] near;
		near = est_mem[ch][31:16];
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			2, 3: return near + skf_pkg::SAMPLE_W'($urandom_range(8)) - skf_pkg::SAMPLE_W'(4);
			default: return skf_pkg::SAMPLE_W'($urandom);
		endcase
	endfunction

	task automatic test_default_noise();
		int i;
		for (i = 0; i < 4; i++)
			send_word(skf_pkg::CH_W'(i), '1);
		send_word(3'd0, 16'h0000);
		send_word(3'd1, 16'h0000);
		send_word(3'd2, 16'h8000);
		send_word(3'd0, 16'h0000);
	endtask

	task automatic test_zero_denominator();
		wait_drained();
		// untouched channels still hold zero variance
		set_noise('0, '0);
		send_word(3'd7, 16'hFFFF);
		send_word(3'd7, 16'h1234);
		send_word(3'd6, 16'h0000);
	endtask

	task automatic test_unity_gain();
		wait_drained();
		set_noise(skf_pkg::PROCESS_NOISE_RST, '0);
		send_word(3'd5, 16'hFFFF);
		send_word(3'd5, 16'h0000);
		send_word(3'd0, 16'h8000);
	endtask

	task automatic test_variance_saturation();
		wait_drained();
		set_noise('1, '1);
		send_word(3'd4, 16'hFFFF);
		send_word(3'd4, 16'h0000);
		send_word(3'd4, 16'h5555);
		wait_drained();
		// saturated variance together with unity gain
		set_noise('1, '0);
		send_word(3'd4, 16'hAAAA);
		send_word(3'd2, 16'hFFFF);
		send_word(3'd3, 16'h0001);
	endtask

	task automatic test_random_traffic(input logic [skf_pkg::DATA_W-1:0] q,
			input logic [skf_pkg::DATA_W-1:0] r);
		int n;
		int burst;
		logic [skf_pkg::CH_W-1:0] ch;
		wait_drained();
		set_noise(q, r);
		n = 0;
		while (n < SEGMENT_WORDS) begin
			// runs on one channel let its estimate settle
			ch = skf_pkg::CH_W'($urandom);
			burst = ($urandom_range(3) == 0) ? $urandom_range(12, 1) : 1;
			while (burst > 0 && n < SEGMENT_WORDS) begin
				send_word(ch, pick_sample(ch));
				burst--;
				n++;
			end
			if ($urandom_range(79) == 0)
				wait_drained();
		end
	endtask

	always @(posedge clk) begin : result_check
		estimate_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (estimates_due.size() == 0) begin
					errors++;
					$display("%0t: word with nothing expected, channel %0d estimate %h",
						$time, m_tdata[2:0], m_tdata[34:3]);
				end else begin
					want = estimates_due.pop_front();
					checked++;
					if (m_tdata[2:0] !== want.ch) begin
						errors++;
						$display("%0t: channel_out expected %0d actual %0d",
							$time, want.ch, m_tdata[2:0]);
					end
					if (m_tdata[34:3] !== want.est) begin
						errors++;
						$display("%0t: estimate ch %0d expected %h actual %h",
							$time, want.ch, want.est, m_tdata[34:3]);
					end
				end
			end
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
			$display("DONE: errors detected");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		int i;
		for (i = 0; i < NUM_CH; i++) begin
			est_mem[i] = '0;
			var_mem[i] = '0;
		end
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_default_noise();
		test_zero_denominator();
		test_unity_gain();
		test_variance_saturation();

		test_random_traffic(skf_pkg::PROCESS_NOISE_RST, skf_pkg::MEASURE_NOISE_RST);
		test_random_traffic('0, '1);

		wait_drained();
		send_idle_pct = 76;
		recv_idle_pct = 29;
		test_random_traffic('1, '0);
		test_random_traffic(skf_pkg::DATA_W'($urandom_range(32'h0010_0000)),
			skf_pkg::DATA_W'($urandom));

		wait_drained();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_traffic(skf_pkg::DATA_W'($urandom), skf_pkg::DATA_W'($urandom));
		test_random_traffic(skf_pkg::DATA_W'($urandom_range(32'h0001_0000)),
			skf_pkg::DATA_W'($urandom_range(32'h0001_0000)));

		wait_drained();
		repeat (25) @(posedge clk);
		$display("sent %0d samples on %0d channels, checked %0d estimates", words_sent,
			NUM_CH, checked);
		$display("%0d noise settings incl. zero, unity-gain and saturating cases",
			noise_settings);
		if (errors == 0 && estimates_due.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("%0d estimates never arrived", estimates_due.size());
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
